[rtl/core/xos_pkg.sv]
// shared types, codes and constants of the xoshiro256** bounded draw block
// no dependencies; every other file of the block but xos_chan_if imports this package

package xos_pkg;

	// default number of state advances after a seed item
	localparam int unsigned WarmupStepsDef = 12;

	// seed mixing constants
	localparam logic [63:0] GoldenMix = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] Sqrt2Mix  = 64'h6A09_E667_F3BC_C908;
	localparam logic [63:0] Sqrt3Mix  = 64'hBB67_AE85_84CA_A73B;

	// rotation and shift amounts of the state update
	localparam int unsigned RotState = 45;
	localparam int unsigned ShfState = 17;

	// item kinds; code 3 means nothing and is ignored
	typedef enum logic [1:0] {
		KIND_SEED = 2'd0,
		KIND_LOAD = 2'd1,
		KIND_DRAW = 2'd2
	} kind_t;

	typedef logic [3:0][63:0] gen_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] seed_word;
		logic [63:0] state_word0;
		logic [63:0] state_word1;
		logic [63:0] state_word2;
		logic [63:0] state_word3;
		logic [31:0] low_bound;
		logic [31:0] high_bound;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value;
		logic [63:0] raw_word;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_seed;
		logic load_words;
		logic capture_draw;
		logic warm_step;
		logic round_en;
		logic mult_en;
		logic sum_en;
		logic out_load;
	} xos_cmd_t;

endpackage

[rtl/core/xos_chan_if.sv]
// valid/ready channel carrying one item per transfer
// payload type is a parameter; used with the structs of xos_pkg

interface xos_chan_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/xos_ctrl.sv]
// controller state machine: sequences seeding warmup and the draw pipeline
// depends on xos_pkg; drives the command struct of xos_dp

module xos_ctrl
	import xos_pkg::*;
#(
	parameter int unsigned WARMUP_STEPS = WarmupStepsDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_kind,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output xos_cmd_t   ctl
);

	localparam int unsigned CntW    = (WARMUP_STEPS < 2) ? 1 : $clog2(WARMUP_STEPS);
	localparam int unsigned LastCnt = (WARMUP_STEPS > 0) ? WARMUP_STEPS - 1 : 0;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WARM  = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_MULT  = 6'b001000,
		ST_SUM   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [CntW-1:0]  cnt_q, cnt_d;
	logic             out_valid_q;
	logic             accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_kind)
						KIND_SEED: begin
							ctl.load_seed = 1'b1;
							cnt_d         = CntW'(LastCnt);
							if (WARMUP_STEPS > 0) begin
								state_d = ST_WARM;
							end
						end
						KIND_LOAD: ctl.load_words = 1'b1;
						KIND_DRAW: begin
							ctl.capture_draw = 1'b1;
							state_d          = ST_ROUND;
						end
						default: ;
					endcase
				end
			end
			ST_WARM: begin
				ctl.warm_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_ROUND: begin
				ctl.round_en = 1'b1;
				state_d      = ST_MULT;
			end
			ST_MULT: begin
				ctl.mult_en = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				ctl.sum_en = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				// wait for the output register to be free
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/xos_dp.sv]
// datapath: generator state, 53-bit rounding, split multiply and output register
// depends on xos_pkg; steered by the command struct from xos_ctrl

module xos_dp
	import xos_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  xos_cmd_t  ctl,
	input  in_item_t  item,
	output out_item_t result
);

	gen_state_t   g_q;
	gen_state_t   g_next;
	logic [63:0]  gen_out;
	logic [63:0]  mul5, rot7, tmp_t, n0, n1, n2, n3, seed0, seed1, seed2;
	logic         reversed;

	logic [31:0]  low_q, range_q;
	logic [63:0]  raw_q;
	logic [3:0]   s_c, s_q;
	logic [63:0]  shifted, rest, half;
	logic         round_up;
	logic [53:0]  m_q;
	logic [63:0]  p_lo_q;
	logic [53:0]  p_hi_q;
	logic [85:0]  prod_q;
	logic [6:0]   sh;
	logic [85:0]  frac;
	out_item_t    result_q;

	// xoshiro256** output and state update, one step
	always_comb begin
		mul5    = g_q[1] + (g_q[1] << 2);
		rot7    = {mul5[56:0], mul5[63:57]};
		gen_out = rot7 + (rot7 << 3);
		tmp_t   = g_q[1] << ShfState;
		n2      = g_q[2] ^ g_q[0];
		n3      = g_q[3] ^ g_q[1];
		n1      = g_q[1] ^ n2;
		n0      = g_q[0] ^ n3;
		g_next[0] = n0;
		g_next[1] = n1;
		g_next[2] = n2 ^ tmp_t;
		g_next[3] = {n3[63-RotState:0], n3[63:64-RotState]};
		seed0   = item.seed_word;
		seed1   = seed0 ^ GoldenMix;
		seed2   = seed1 ^ Sqrt2Mix;
	end

	assign reversed = item.low_bound > item.high_bound;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q <= '0;
		end else if (ctl.load_seed) begin
			g_q <= {seed2 ^ Sqrt3Mix, seed2, seed1, seed0};
		end else if (ctl.load_words) begin
			g_q <= {item.state_word3, item.state_word2, item.state_word1, item.state_word0};
		end else if (ctl.warm_step || (ctl.capture_draw && !reversed)) begin
			g_q <= g_next;
		end
	end

	// draw operands; a reversed draw carries zero so the scaled part is zero
	always_ff @(posedge clk) begin
		if (ctl.capture_draw) begin
			low_q   <= item.low_bound;
			range_q <= item.high_bound - item.low_bound + 32'd1;
			raw_q   <= reversed ? '0 : gen_out;
		end
	end

	// rounding to 53 significant bits, ties to even
	always_comb begin
		s_c = '0;
		for (int i = 0; i < 11; i++) begin
			if (raw_q[53+i]) begin
				s_c = 4'(i + 1);
			end
		end
		shifted  = raw_q >> s_c;
		rest     = raw_q & ~({64{1'b1}} << s_c);
		half     = (s_c == '0) ? '0 : (64'd1 << (s_c - 4'd1));
		round_up = (s_c != '0) && ((rest > half) || ((rest == half) && shifted[0]));
	end

	always_ff @(posedge clk) begin
		if (ctl.round_en) begin
			m_q <= {1'b0, shifted[52:0]} + 54'(round_up);
			s_q <= s_c;
		end
		if (ctl.mult_en) begin
			p_lo_q <= 64'(m_q[31:0]) * 64'(range_q);
			p_hi_q <= 54'(m_q[53:32]) * 54'(range_q);
		end
		if (ctl.sum_en) begin
			prod_q <= {p_hi_q, 32'b0} + 86'(p_lo_q);
		end
	end

	// scaled part is product over 2^(64-s), always below 2^32
	assign sh   = 7'd64 - 7'(s_q);
	assign frac = prod_q >> sh;

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			result_q.value    <= low_q + frac[31:0];
			result_q.raw_word <= raw_q;
		end
	end

	assign result = result_q;

endmodule

[rtl/core/xoshiro256ss_bounded_random.sv]
// xoshiro256** generator with bounded 32-bit draws: load, seed and draw items
// a draw passes the round, multiply and sum states; the finishing state then loads
// the result register (later if res stalls); loads take one item per cycle, while a
// draw or a seed's warmup holds off new items, as they share the one state-update step
// reset: arst_n clears the four state words, the controller and the result valid
// depends on xos_pkg, xos_chan_if, xos_ctrl and xos_dp

module xoshiro256ss_bounded_random
	import xos_pkg::*;
#(
	parameter int unsigned WARMUP_STEPS = WarmupStepsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	xos_chan_if.sink          cmd,
	xos_chan_if.source        res
);

	// command bundle from the sequencer to the datapath
	xos_cmd_t   ctl;
	in_item_t   item;
	out_item_t  result;

	// input item is read directly at its transfer; no input register needed
	assign item = cmd.payload;

	// controller: one item at a time, output register frees the result side
	xos_ctrl #(
		.WARMUP_STEPS (WARMUP_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_kind   (item.kind),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.ctl       (ctl)
	);

	// datapath: state words, rounding, split 32-bit multiplies, result register
	xos_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item),
		.result (result)
	);

	// result register drives the output payload; it holds while res stalls
	assign res.payload = result;

endmodule

[rtl/core/xos_check.sv]
// port-level checker for the bounded draw block, bound to the top level
// depends on xos_pkg for the item kind codes

module xos_check
	import xos_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic [95:0] out_payload
);

	// a waiting result keeps its value until transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result changed or dropped while stalled");

	// a draw occupies the block, so no transfer right after it
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_kind == KIND_DRAW) |=> !in_ready)
		else $error("ready after a draw transfer");

	// a state load does not occupy the block, so it is ready again right after it
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_kind == KIND_LOAD) |=> in_ready)
		else $error("not ready after a load transfer");

	// a new result only comes from the finishing step, never from idle
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a draw in progress");

endmodule

bind xoshiro256ss_bounded_random xos_check u_xos_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (cmd.valid),
	.in_ready    (cmd.ready),
	.in_kind     (cmd.payload.kind),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.out_payload (res.payload)
);

[test/tb_top.sv]
`timescale 1ns / 100ps
// self-checking bench for xoshiro256ss_bounded_random: seed, load and draw transfers
// depends on xos_pkg, xos_chan_if and the block itself

module tb_top
	import xos_pkg::*;
;

	// idle cycles without any transfer before the run is declared hung
	localparam int unsigned HangLimit = 1000;
	// cycles allowed after the last expected draw for stray results to show up
	localparam int unsigned DrainCycles = 20;
	// kind code that the block must ignore
	localparam logic [1:0] KindUnused = 2'd3;
	localparam int unsigned RandomItems = 1600;

	// predictor of the generator plus the queue of draws still owed by the block
	class draw_scoreboard;
		gen_state_t words;
		out_item_t  expected_draws[$];
		int unsigned errors;
		int unsigned shown;

		function new();
			words  = '0;
			errors = 0;
			shown  = 0;
		endfunction

		function logic [63:0] rotl64(logic [63:0] v, int unsigned n);
			return (v << n) | (v >> (64 - n));
		endfunction

		// one xoshiro256** step, returns the scrambled output of the old state
		function logic [63:0] advance_state();
			logic [63:0] outv;
			logic [63:0] t;
			outv = rotl64(words[1] * 64'd5, 7) * 64'd9;
			t = words[1] << ShfState;
			words[2] ^= words[0];
			words[3] ^= words[1];
			words[1] ^= words[2];
			words[0] ^= words[3];
			words[2] ^= t;
			words[3] = rotl64(words[3], RotState);
			return outv;
		endfunction

		// floor(round53(raw) * span / 2^64), exact in 128 bits
		function logic [31:0] scaled_fraction(logic [63:0] raw, logic [31:0] span);
			int unsigned width;
			int unsigned shift;
			logic [63:0]  mant;
			logic [63:0]  rest;
			logic [63:0]  half;
			logic [127:0] prod;
			width = 0;
			for (int b = 0; b < 64; b++)
				if (raw[b])
					width = b + 1;
			shift = (width > 53) ? width - 53 : 0;
			mant = raw >> shift;
			if (shift > 0) begin
				rest = raw & ((64'd1 << shift) - 64'd1);
				half = 64'd1 << (shift - 1);
				if (rest > half || (rest == half && mant[0]))
					mant = mant + 64'd1;
			end
			prod = {64'd0, mant} * {96'd0, span};
			prod = prod >> (64 - shift);
			return prod[31:0];
		endfunction

		function void note_cmd(in_item_t item);
			out_item_t   want;
			logic [31:0] span;
			case (item.kind)
			KIND_SEED: begin
				words[0] = item.seed_word;
				words[1] = words[0] ^ GoldenMix;
				words[2] = words[1] ^ Sqrt2Mix;
				words[3] = words[2] ^ Sqrt3Mix;
				repeat (WarmupStepsDef)
					void'(advance_state());
			end
			KIND_LOAD: begin
				words[0] = item.state_word0;
				words[1] = item.state_word1;
				words[2] = item.state_word2;
				words[3] = item.state_word3;
			end
			KIND_DRAW: begin
				if (item.low_bound > item.high_bound) begin
					// reversed bounds: no advance, low bound comes back
					want.value    = item.low_bound;
					want.raw_word = '0;
				end else begin
					span = item.high_bound - item.low_bound + 32'd1;
					want.raw_word = advance_state();
					want.value = item.low_bound + scaled_fraction(want.raw_word, span);
				end
				expected_draws.push_back(want);
			end
			default: begin
			end
			endcase
		endfunction

		function void check_draw(out_item_t got);
			out_item_t want;
			if (expected_draws.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected draw: value %h raw %h", got.value, got.raw_word);
				end
				return;
			end
			want = expected_draws.pop_front();
			if (got.value !== want.value || got.raw_word !== want.raw_word) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("draw mismatch: value exp %h got %h, raw exp %h got %h",
						want.value, got.value, want.raw_word, got.raw_word);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic steady;
	int unsigned idle_cycles;
	draw_scoreboard board;

	xos_chan_if #(.item_t(in_item_t))  cmd_ch();
	xos_chan_if #(.item_t(out_item_t)) res_ch();

	xoshiro256ss_bounded_random #(
		.WARMUP_STEPS(WarmupStepsDef)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// gap length: mostly none or short, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// modular inverse of an odd word, newton iteration
	function automatic logic [63:0] odd_inverse(logic [63:0] a);
		logic [63:0] inv;
		inv = a;
		repeat (6)
			inv = inv * (64'd2 - a * inv);
		return inv;
	endfunction

	// state word 1 that makes the next raw output equal target
	function automatic logic [63:0] word1_for_raw(logic [63:0] target);
		logic [63:0] x;
		x = target * odd_inverse(64'd9);
		x = (x >> 7) | (x << 57);
		return x * odd_inverse(64'd5);
	endfunction

	// every field random, so unused fields carry junk too
	function automatic in_item_t random_item();
		in_item_t item;
		item.kind        = 2'($urandom_range(0, 3));
		item.seed_word   = {$urandom, $urandom};
		item.state_word0 = {$urandom, $urandom};
		item.state_word1 = {$urandom, $urandom};
		item.state_word2 = {$urandom, $urandom};
		item.state_word3 = {$urandom, $urandom};
		item.low_bound   = $urandom;
		item.high_bound  = $urandom;
		return item;
	endfunction

	function automatic in_item_t seed_item(logic [63:0] seed);
		in_item_t item;
		item = random_item();
		item.kind = KIND_SEED;
		item.seed_word = seed;
		return item;
	endfunction

	function automatic in_item_t load_item(logic [63:0] w0, logic [63:0] w1,
		logic [63:0] w2, logic [63:0] w3);
		in_item_t item;
		item = random_item();
		item.kind = KIND_LOAD;
		item.state_word0 = w0;
		item.state_word1 = w1;
		item.state_word2 = w2;
		item.state_word3 = w3;
		return item;
	endfunction

	function automatic in_item_t draw_item(logic [31:0] lo, logic [31:0] hi);
		in_item_t item;
		item = random_item();
		item.kind = KIND_DRAW;
		item.low_bound = lo;
		item.high_bound = hi;
		return item;
	endfunction

	// one command transfer; valid stays high straight into the next item when no gap
	task automatic send_cmd(input in_item_t item);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= item;
		do @(posedge clk); while (!cmd_ch.ready);
		board.note_cmd(item);
	endtask

	// result side back-pressure: bursts of ready and stalls, none while steady
	initial begin
		int unsigned hold;
		logic level;
		hold  = 0;
		level = 1'b1;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (steady) begin
				level = 1'b1;
				hold  = 0;
			end else if (hold == 0) begin
				if ($urandom_range(0, 9) < 7) begin
					level = 1'b1;
					hold  = $urandom_range(1, 8);
				end else begin
					level = 1'b0;
					hold  = 1 + pick_gap();
				end
			end else begin
				hold--;
			end
			res_ch.ready <= level;
		end
	end

	// result checking and hang watchdog
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			board.check_draw(res_ch.payload);
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= HangLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		in_item_t    item;
		logic [63:0] target;
		logic [31:0] lo;
		logic [31:0] hi;
		int unsigned counted;
		int unsigned r;

		board = new();
		steady = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.payload <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// draws straight out of reset: all-zero state gives raw zero
		send_cmd(draw_item(32'd0, 32'hFFFF_FFFF));
		// reversed bounds leave the state alone
		send_cmd(draw_item(32'd5, 32'd4));
		send_cmd(seed_item(64'd0));
		// full range wraps to zero, value is the low bound
		send_cmd(draw_item(32'd0, 32'hFFFF_FFFF));
		send_cmd(draw_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_cmd(draw_item(32'd0, 32'd0));
		send_cmd(seed_item(64'hFFFF_FFFF_FFFF_FFFF));
		send_cmd(draw_item(32'h8000_0000, 32'hFFFF_FFFE));
		send_cmd(draw_item(32'hFFFF_FFFF, 32'd0));
		send_cmd(draw_item(32'd0, 32'd1));
		// raw output of all ones rounds up to 2^64, sum wraps past the top
		send_cmd(load_item('1, word1_for_raw('1), '1, '1));
		send_cmd(draw_item(32'd1, 32'hFFFF_FFFF));
		// exact halfway tail with even mantissa stays put
		send_cmd(load_item('0, word1_for_raw(64'h8000_0000_0000_0400), '0, '0));
		send_cmd(draw_item(32'd0, 32'hFFFF_FFFE));
		// exact halfway tail with odd mantissa rounds up
		send_cmd(load_item('1, word1_for_raw(64'h8000_0000_0000_0C00), '0, '1));
		send_cmd(draw_item(32'd0, 32'hFFFF_FFFE));
		// short raw words need no rounding
		send_cmd(load_item('0, word1_for_raw(64'd1), '0, '0));
		send_cmd(draw_item(32'd0, 32'hFFFF_FFFE));
		send_cmd(load_item('0, word1_for_raw(64'h001F_FFFF_FFFF_FFFF), '0, '0));
		send_cmd(draw_item(32'h7FFF_FFFF, 32'hFFFF_FFFE));
		send_cmd(load_item('0, '0, '0, '0));
		send_cmd(draw_item(32'd3, 32'd9));
		// unused kind must be ignored
		item = random_item();
		item.kind = KindUnused;
		send_cmd(item);
		send_cmd(draw_item(32'd0, 32'hFFFF_FFFE));

		// random part, ignored items not counted
		counted = 0;
		while (counted < RandomItems) begin
			// two stretches with no idling on either side
			steady = (counted >= 400 && counted < 550) || (counted >= 1100 && counted < 1250);
			item = random_item();
			r = $urandom_range(0, 99);
			if (r < 4) begin
				item.kind = KIND_SEED;
			end else if (r < 8) begin
				item.kind = KIND_LOAD;
				if ($urandom_range(0, 1) == 0) begin
					// aim the next raw word at a rounding corner
					target = {$urandom, $urandom};
					target[63] = 1'b1;
					case ($urandom_range(0, 2))
					0: target[10:0] = 11'h400;
					1: target[10:0] = 11'h7FF;
					default: target[63:11] = '1;
					endcase
					item.state_word1 = word1_for_raw(target);
				end
			end else if (r < 10) begin
				item.kind = KindUnused;
			end else if (r < 14) begin
				item.kind = KIND_DRAW;
				lo = $urandom_range(1, 32'hFFFF_FFFF);
				item.low_bound  = lo;
				item.high_bound = $urandom_range(0, lo - 1);
			end else begin
				item.kind = KIND_DRAW;
				r = $urandom_range(0, 99);
				if (r < 25) begin
					lo = $urandom;
					hi = lo + $urandom_range(0, 15);
					if (hi < lo)
						hi = 32'hFFFF_FFFF;
				end else if (r < 35) begin
					lo = 32'd0;
					hi = 32'hFFFF_FFFF;
				end else if (r < 45) begin
					lo = 32'd0;
					hi = $urandom;
				end else begin
					lo = $urandom;
					hi = $urandom;
					if (lo > hi) begin
						lo = lo ^ hi;
						hi = lo ^ hi;
						lo = lo ^ hi;
					end
				end
				item.low_bound  = lo;
				item.high_bound = hi;
			end
			send_cmd(item);
			if (item.kind != KindUnused)
				counted++;
		end
		steady = 1'b0;
		cmd_ch.valid <= 1'b0;

		// drain, then leave room for any stray result
		while (board.expected_draws.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (board.errors == 0 && board.expected_draws.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/xos_pkg.sv
rtl/core/xos_chan_if.sv
rtl/core/xos_ctrl.sv
rtl/core/xos_dp.sv
rtl/core/xoshiro256ss_bounded_random.sv
rtl/core/xos_check.sv
test/tb_top.sv
